@@ hw/rtl/sbq_pkg.sv @@
package sbq_pkg;

	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_FRAC_BITS = 21;
	localparam int STATE_BITS     = 32;
	localparam int REG_BITS       = 24;
	localparam int GAIN_FRAC_BITS = 23;
	localparam int PEAK_BITS      = SAMPLE_BITS - 1;
	localparam int NUM_CH         = 2;
	localparam int REG_IDX_W      = 3;

	// Multiplier operands hold a sign-extended register or sample, or a zero-extended gain.
	localparam int MUL_W  = REG_BITS + 1;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W  = PROD_W + 2;

	localparam logic signed [REG_BITS-1:0] COEF_ONE  = REG_BITS'(1) <<< COEF_FRAC_BITS;
	localparam logic [REG_BITS-1:0]        GAIN_ONE  = REG_BITS'(1) << GAIN_FRAC_BITS;
	localparam logic [REG_BITS-1:0]        PAN_CENTER = REG_BITS'(5931642);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_B0,
		REG_B1,
		REG_B2,
		REG_A1,
		REG_A2,
		REG_TRACK_GAIN,
		REG_PAN_LEFT,
		REG_PAN_RIGHT
	} reg_idx_t;

	typedef struct packed {
		logic signed [REG_BITS-1:0] b0;
		logic signed [REG_BITS-1:0] b1;
		logic signed [REG_BITS-1:0] b2;
		logic signed [REG_BITS-1:0] a1;
		logic signed [REG_BITS-1:0] a2;
		logic [REG_BITS-1:0]        track_gain;
		logic [REG_BITS-1:0]        pan_left;
		logic [REG_BITS-1:0]        pan_right;
	} cfg_regs_t;

	typedef enum logic [2:0] {
		MUL_B0X,
		MUL_B1X,
		MUL_A1Y,
		MUL_B2X,
		MUL_A2Y,
		MUL_GY,
		MUL_PG
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     y_en;
		logic     acc_en;
		logic     z1_en;
		logic     z2_en;
		logic     g_en;
		logic     mag_en;
		logic     fin_en;
	} dp_cmd_t;

endpackage

@@ hw/rtl/sbq_cfg.sv @@
module sbq_cfg
	import sbq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_BITS-1:0]  cfg_data,
	output cfg_regs_t            regs
);

	cfg_regs_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.b0         <= COEF_ONE;
			regs_q.b1         <= '0;
			regs_q.b2         <= '0;
			regs_q.a1         <= '0;
			regs_q.a2         <= '0;
			regs_q.track_gain <= GAIN_ONE;
			regs_q.pan_left   <= PAN_CENTER;
			regs_q.pan_right  <= PAN_CENTER;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_B0:         regs_q.b0         <= cfg_data;
				REG_B1:         regs_q.b1         <= cfg_data;
				REG_B2:         regs_q.b2         <= cfg_data;
				REG_A1:         regs_q.a1         <= cfg_data;
				REG_A2:         regs_q.a2         <= cfg_data;
				REG_TRACK_GAIN: regs_q.track_gain <= cfg_data;
				REG_PAN_LEFT:   regs_q.pan_left   <= cfg_data;
				REG_PAN_RIGHT:  regs_q.pan_right  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

@@ hw/rtl/sbq_ctrl.sv @@
module sbq_ctrl
	import sbq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	output dp_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_B0,
		ST_B1,
		ST_A1,
		ST_B2,
		ST_A2,
		ST_GN,
		ST_GS,
		ST_PN,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   fin_go;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.mul_sel = MUL_B0X;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = accept;
			end
			ST_B0: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_B0X;
			end
			ST_B1: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_B1X;
				cmd.y_en = 1'b1;
			end
			ST_A1: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_A1Y;
				cmd.acc_en = 1'b1;
			end
			ST_B2: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_B2X;
				cmd.z1_en = 1'b1;
			end
			ST_A2: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_A2Y;
				cmd.acc_en = 1'b1;
			end
			ST_GN: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_GY;
				cmd.z2_en = 1'b1;
			end
			ST_GS: begin
				cmd.g_en = 1'b1;
			end
			ST_PN: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_PG;
				cmd.mag_en = 1'b1;
			end
			ST_FIN: begin
				cmd.fin_en = fin_go;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_B0;
				ST_B0:   state_q <= ST_B1;
				ST_B1:   state_q <= ST_A1;
				ST_A1:   state_q <= ST_B2;
				ST_B2:   state_q <= ST_A2;
				ST_A2:   state_q <= ST_GN;
				ST_GN:   state_q <= ST_GS;
				ST_GS:   state_q <= ST_PN;
				ST_PN:   state_q <= ST_FIN;
				ST_FIN:  if (fin_go) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_B0))
		else $error("accepted beat did not start the filter sequence");

	a_valid_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result raised without a finishing step");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin_en |-> (!out_valid_q || !out_stall))
		else $error("pending result overwritten");

	a_fin_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin_en |=> (state_q == ST_IDLE && out_valid_q))
		else $error("finishing step did not present a result");

endmodule

@@ hw/rtl/sbq_dp.sv @@
module sbq_dp
	import sbq_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  dp_cmd_t                       cmd,
	input  cfg_regs_t                     regs,
	input  logic signed [SAMPLE_BITS-1:0] left_sample,
	input  logic signed [SAMPLE_BITS-1:0] right_sample,
	input  logic signed [SAMPLE_BITS-1:0] bus_left_in,
	input  logic signed [SAMPLE_BITS-1:0] bus_right_in,
	input  logic                          block_start,
	output logic signed [SAMPLE_BITS-1:0] bus_left_out,
	output logic signed [SAMPLE_BITS-1:0] bus_right_out,
	output logic [PEAK_BITS-1:0]          block_peak,
	output logic                          bus_saturated
);

	localparam logic signed [ACC_W-1:0] SAMPLE_MAX = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] SAMPLE_MIN = -SAMPLE_MAX - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] STATE_MAX = (ACC_W'(1) <<< (STATE_BITS - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] STATE_MIN = -STATE_MAX - ACC_W'(1);

	// Round to nearest with ties toward plus infinity, then drop s fraction bits.
	function automatic logic signed [ACC_W-1:0] rnd_shift(input logic signed [ACC_W-1:0] v,
		input int s);
		logic signed [ACC_W-1:0] half;
		half = ACC_W'(1) <<< (s - 1);
		return (v + half) >>> s;
	endfunction

	function automatic logic sample_over(input logic signed [ACC_W-1:0] v);
		return (v > SAMPLE_MAX) || (v < SAMPLE_MIN);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		r = v;
		if (v > SAMPLE_MAX) begin
			r = SAMPLE_MAX;
		end else if (v < SAMPLE_MIN) begin
			r = SAMPLE_MIN;
		end
		return r[SAMPLE_BITS-1:0];
	endfunction

	function automatic logic signed [STATE_BITS-1:0] sat_state(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		r = v;
		if (v > STATE_MAX) begin
			r = STATE_MAX;
		end else if (v < STATE_MIN) begin
			r = STATE_MIN;
		end
		return r[STATE_BITS-1:0];
	endfunction

	// Full-scale negative clips to the largest positive magnitude.
	function automatic logic [PEAK_BITS-1:0] magnitude(input logic signed [SAMPLE_BITS-1:0] g);
		logic [SAMPLE_BITS-1:0] neg;
		logic [PEAK_BITS-1:0]   m;
		neg = -g;
		if (!g[SAMPLE_BITS-1]) begin
			m = g[PEAK_BITS-1:0];
		end else if (neg[SAMPLE_BITS-1]) begin
			m = '1;
		end else begin
			m = neg[PEAK_BITS-1:0];
		end
		return m;
	endfunction

	logic signed [SAMPLE_BITS-1:0] x_q   [NUM_CH];
	logic signed [SAMPLE_BITS-1:0] bus_q [NUM_CH];
	logic                          start_q;
	logic [PEAK_BITS-1:0]          peak_q;

	logic [REG_BITS-1:0]           pan       [NUM_CH];
	logic [PEAK_BITS-1:0]          mag_w     [NUM_CH];
	logic                          over_w    [NUM_CH];
	logic signed [SAMPLE_BITS-1:0] bus_out_w [NUM_CH];

	logic [PEAK_BITS-1:0] peak_base;
	logic [PEAK_BITS-1:0] peak_mid;
	logic [PEAK_BITS-1:0] peak_next;

	assign pan[0] = regs.pan_left;
	assign pan[1] = regs.pan_right;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q[0]   <= left_sample;
			x_q[1]   <= right_sample;
			bus_q[0] <= bus_left_in;
			bus_q[1] <= bus_right_in;
			start_q  <= block_start;
		end
	end

	for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
		logic signed [MUL_W-1:0]       op_a;
		logic signed [MUL_W-1:0]       op_b;
		logic signed [PROD_W-1:0]      p_q;
		logic signed [ACC_W-1:0]       acc_q;
		logic signed [SAMPLE_BITS-1:0] y_q;
		logic signed [SAMPLE_BITS-1:0] g_q;
		logic [PEAK_BITS-1:0]          mag_q;
		logic signed [SAMPLE_BITS-1:0] out_q;
		logic                          over_q;
		logic signed [STATE_BITS-1:0]  z1_q;
		logic signed [STATE_BITS-1:0]  z2_q;
		logic signed [ACC_W-1:0]       p_ext;
		logic signed [ACC_W-1:0]       diff;
		logic signed [ACC_W-1:0]       bus_sum;

		assign p_ext   = ACC_W'(p_q);
		assign diff    = rnd_shift(acc_q - p_ext, COEF_FRAC_BITS);
		assign bus_sum = ACC_W'(bus_q[ch]) + rnd_shift(p_ext, GAIN_FRAC_BITS);

		always_comb begin
			case (cmd.mul_sel)
				MUL_B0X: begin
					op_a = MUL_W'(regs.b0);
					op_b = MUL_W'(x_q[ch]);
				end
				MUL_B1X: begin
					op_a = MUL_W'(regs.b1);
					op_b = MUL_W'(x_q[ch]);
				end
				MUL_A1Y: begin
					op_a = MUL_W'(regs.a1);
					op_b = MUL_W'(y_q);
				end
				MUL_B2X: begin
					op_a = MUL_W'(regs.b2);
					op_b = MUL_W'(x_q[ch]);
				end
				MUL_A2Y: begin
					op_a = MUL_W'(regs.a2);
					op_b = MUL_W'(y_q);
				end
				MUL_GY: begin
					op_a = $signed({1'b0, regs.track_gain});
					op_b = MUL_W'(y_q);
				end
				MUL_PG: begin
					op_a = $signed({1'b0, pan[ch]});
					op_b = MUL_W'(g_q);
				end
				default: begin
					op_a = '0;
					op_b = '0;
				end
			endcase
		end

		always_ff @(posedge clk) begin
			if (cmd.mul_en) begin
				p_q <= op_a * op_b;
			end
			if (cmd.y_en) begin
				y_q <= sat_sample(rnd_shift(p_ext, COEF_FRAC_BITS) + ACC_W'(z1_q));
			end
			if (cmd.acc_en) begin
				acc_q <= p_ext;
			end
			if (cmd.g_en) begin
				g_q <= sat_sample(rnd_shift(p_ext, GAIN_FRAC_BITS));
			end
			if (cmd.mag_en) begin
				mag_q <= magnitude(g_q);
			end
			if (cmd.fin_en) begin
				out_q  <= sat_sample(bus_sum);
				over_q <= sample_over(bus_sum);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				z1_q <= '0;
				z2_q <= '0;
			end else begin
				if (cmd.z1_en) begin
					z1_q <= sat_state(diff + ACC_W'(z2_q));
				end
				if (cmd.z2_en) begin
					z2_q <= sat_state(diff);
				end
			end
		end

		assign mag_w[ch]     = mag_q;
		assign over_w[ch]    = over_q;
		assign bus_out_w[ch] = out_q;
	end

	assign peak_base = start_q ? '0 : peak_q;
	assign peak_mid  = (mag_w[0] > peak_base) ? mag_w[0] : peak_base;
	assign peak_next = (mag_w[1] > peak_mid) ? mag_w[1] : peak_mid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
		end else if (cmd.fin_en) begin
			peak_q <= peak_next;
		end
	end

	assign bus_left_out  = bus_out_w[0];
	assign bus_right_out = bus_out_w[1];
	assign block_peak    = peak_q;
	assign bus_saturated = over_w[0] || over_w[1];

	a_peak_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fin_en && !start_q) |=> (peak_q >= $past(peak_q)))
		else $error("running peak fell without a block start");

	a_peak_covers: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin_en |=> (peak_q >= $past(mag_w[0]) && peak_q >= $past(mag_w[1])))
		else $error("running peak below a post-gain magnitude");

	a_state_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!cmd.z1_en && !cmd.z2_en) |=> $stable(g_lane[0].z1_q) && $stable(g_lane[0].z2_q))
		else $error("left filter state changed outside its update steps");

endmodule

@@ hw/rtl/stereo_biquad_channel_strip_core.sv @@
// One beat carries a stereo sample pair and the two bus sums so far, and returns one beat
// with the updated, saturated bus sums, the running block peak and a clip flag. Each
// channel has its own 25x25 signed multiplier, shared by the seven products of that
// channel, so each beat steps through them in turn, and the next beat is accepted only
// after the last step of the previous one. The output register lets the next beat start
// while a result is still stalled; that beat then waits in its last step until the
// earlier result is taken. Coefficient and gain writes take effect immediately and
// should be made only while no beat is in flight.
module stereo_biquad_channel_strip_core
	import sbq_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] left_sample,
	input  logic signed [SAMPLE_BITS-1:0] right_sample,
	input  logic signed [SAMPLE_BITS-1:0] bus_left_in,
	input  logic signed [SAMPLE_BITS-1:0] bus_right_in,
	input  logic                          block_start,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] bus_left_out,
	output logic signed [SAMPLE_BITS-1:0] bus_right_out,
	output logic [PEAK_BITS-1:0]          block_peak,
	output logic                          bus_saturated,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [REG_IDX_W-1:0]          cfg_index,
	input  logic [REG_BITS-1:0]           cfg_data
);

	cfg_regs_t regs;
	dp_cmd_t   cmd;

	sbq_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	sbq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	sbq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.regs          (regs),
		.left_sample   (left_sample),
		.right_sample  (right_sample),
		.bus_left_in   (bus_left_in),
		.bus_right_in  (bus_right_in),
		.block_start   (block_start),
		.bus_left_out  (bus_left_out),
		.bus_right_out (bus_right_out),
		.block_peak    (block_peak),
		.bus_saturated (bus_saturated)
	);

endmodule
